// ===== rtl/dual_axis_incremental_pid_top_assert.svh =====
// ---------------------------------------------------------------------------
// dual_axis_incremental_pid_top_assert.svh
// Assertion macros shared by the controller RTL.
// ---------------------------------------------------------------------------
`ifndef DUAL_AXIS_INCREMENTAL_PID_TOP_ASSERT_SVH
`define DUAL_AXIS_INCREMENTAL_PID_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dapid_pkg.sv =====
// ---------------------------------------------------------------------------
// dapid_pkg
// Shared types and constants of the two-axis incremental PID controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dapid_pkg;

  localparam int GAIN_W    = 20;
  localparam int LIMIT_W   = 15;
  localparam int DRIVE_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

  // reset values (gains about 0.3 / 0.003 / 0.3 in Q4.16)
  localparam logic [GAIN_W-1:0]  P_GAIN_RST         = 20'd19661;
  localparam logic [GAIN_W-1:0]  I_GAIN_RST         = 20'd197;
  localparam logic [GAIN_W-1:0]  D_GAIN_RST         = 20'd19661;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd20;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 15'd400;

  // operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  p_gain;
    logic [GAIN_W-1:0]  i_gain;
    logic [GAIN_W-1:0]  d_gain;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

endpackage

// ===== rtl/dual_axis_incremental_pid_top.sv =====
// ---------------------------------------------------------------------------
// dual_axis_incremental_pid_top
// Pipeline: four registers (error, products, truncated sum, output with
//   accumulator update). Throughput: one transaction per cycle unless
//   out_tready stalls the output; the accumulator read-modify-write sits in
//   the last stage alone, so back-to-back steps on one axis never wait.
// Reset (rst_n low, synchronous): pipeline empty, errors and accumulators
//   zero, registers at their defaults. No clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_axis_incremental_pid_top_assert.svh"

module dual_axis_incremental_pid_top
  import dapid_pkg::*;
#(
  parameter int AXIS_COUNT    = 2,
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // tdata: measured_position, target_position (low bits up), zero padded
  input  logic [((2*POSITION_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: operation [0], axis [1]
  input  logic [1:0]           in_tuser,
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // tdata: drive
  output logic [DRIVE_W-1:0]   out_tdata,
  // tuser: axis_out
  output logic [0:0]           out_tuser
);

  // error, error difference, gain-as-signed, product, sum and term widths
  localparam int EW    = POSITION_BITS + 1;
  localparam int DW    = POSITION_BITS + 2;
  localparam int GW    = GAIN_W + 1;
  localparam int PW    = GW + EW;
  localparam int QW    = GW + DW;
  localparam int SW    = QW + 1;
  localparam int TW    = SW - FRAC_W;
  localparam int AW    = TW + 1;
  localparam int AXI_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  cfg_t cfg;

  dapid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------- handshake
  // Each stage loads when empty or when its content moves on.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic s1_fire, s3_fire;

  assign out_ready = !out_v_r || out_tready;
  assign s3_ready  = !s3_v_r  || out_ready;
  assign s2_ready  = !s2_v_r  || s3_ready;
  assign s1_ready  = !s1_v_r  || s2_ready;
  assign in_tready = s1_ready;

  assign s1_fire = s1_v_r && s2_ready;
  assign s3_fire = s3_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_r  <= in_tvalid;
      if (s2_ready)  s2_v_r  <= s1_v_r;
      if (s3_ready)  s3_v_r  <= s2_v_r;
      if (out_ready) out_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // error = measured - target, one bit wider so it never wraps
  logic [POSITION_BITS-1:0] meas, targ;
  logic signed [EW-1:0]     err_nxt;
  logic signed [EW-1:0]     s1_err_r;
  logic                     s1_op_r, s1_ax_r;

  assign meas    = in_tdata[POSITION_BITS-1:0];
  assign targ    = in_tdata[2*POSITION_BITS-1:POSITION_BITS];
  assign err_nxt = $signed({meas[POSITION_BITS-1], meas})
                 - $signed({targ[POSITION_BITS-1], targ});

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_err_r <= err_nxt;
      s1_op_r  <= in_tuser[0];
      s1_ax_r  <= in_tuser[1];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Previous error is read and written here only, so consecutive steps on
  // the same axis see each other without forwarding.
  logic [AXIS_COUNT-1:0][EW-1:0] prev_r;
  logic [AXI_W-1:0]              ax1_idx;
  logic                          ax1_ok;
  logic signed [EW-1:0]          prev_sel;
  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          p_prod, i_prod;
  logic signed [QW-1:0]          d_prod;
  logic signed [PW-1:0]          s2_p_r, s2_i_r;
  logic signed [QW-1:0]          s2_d_r;
  logic                          s2_op_r, s2_ax_r;

  assign ax1_ok   = (32'(s1_ax_r) < AXIS_COUNT);
  assign ax1_idx  = AXI_W'(s1_ax_r);
  assign prev_sel = ax1_ok ? $signed(prev_r[ax1_idx]) : '0;
  assign diff     = $signed({s1_err_r[EW-1], s1_err_r})
                  - $signed({prev_sel[EW-1], prev_sel});
  assign p_prod   = PW'($signed({1'b0, cfg.p_gain})) * PW'(s1_err_r);
  assign i_prod   = PW'($signed({1'b0, cfg.i_gain})) * PW'(s1_err_r);
  assign d_prod   = QW'($signed({1'b0, cfg.d_gain})) * QW'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (s1_fire && s1_op_r == OP_STEP && ax1_ok) begin
      prev_r[ax1_idx] <= s1_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_p_r  <= p_prod;
      s2_i_r  <= i_prod;
      s2_d_r  <= d_prod;
      s2_op_r <= s1_op_r;
      s2_ax_r <= s1_ax_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Clamp I term to +-(integral_limit << 16), sum, truncate toward zero.
  // Truncation: bias negative sums by 2^16-1, then arithmetic shift.
  logic signed [SW-1:0] ilim, p_ext, i_ext, d_ext, i_clamp, sum, biased;
  logic signed [TW-1:0] term_nxt;
  logic signed [TW-1:0] s3_term_r;
  logic                 s3_op_r, s3_ax_r;

  assign ilim  = SW'($signed({1'b0, cfg.integral_limit, {FRAC_W{1'b0}}}));
  assign p_ext = SW'(s2_p_r);
  assign i_ext = SW'(s2_i_r);
  assign d_ext = SW'(s2_d_r);

  always_comb begin
    i_clamp = i_ext;
    if (i_clamp >= ilim)  i_clamp = ilim;
    if (i_clamp <= -ilim) i_clamp = -ilim;
  end

  assign sum      = p_ext + i_clamp + d_ext;
  assign biased   = sum + (sum[SW-1] ? SW'({FRAC_W{1'b1}}) : SW'(0));
  assign term_nxt = TW'(biased >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_term_r <= term_nxt;
      s3_op_r   <= s2_op_r;
      s3_ax_r   <= s2_ax_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Accumulate and saturate at +-output_limit; the full-width sum never wraps.
  logic [AXIS_COUNT-1:0][DRIVE_W-1:0] acc_r;
  logic [AXI_W-1:0]                   ax3_idx;
  logic                               ax3_ok;
  logic signed [AW-1:0]               olim, acc_sum, acc_sat;
  logic signed [DRIVE_W-1:0]          drive_nxt;
  logic                               axis_out_nxt;
  logic signed [DRIVE_W-1:0]          out_drive_r;
  logic                               out_axis_r;

  assign ax3_ok  = (32'(s3_ax_r) < AXIS_COUNT);
  assign ax3_idx = AXI_W'(s3_ax_r);
  assign olim    = AW'($signed({1'b0, cfg.output_limit}));
  assign acc_sum = AW'($signed(ax3_ok ? acc_r[ax3_idx] : '0)) + AW'(s3_term_r);

  always_comb begin
    acc_sat = acc_sum;
    if (acc_sat <= -olim) acc_sat = -olim;
    if (acc_sat >= olim)  acc_sat = olim;
  end

  always_comb begin
    if (s3_op_r == OP_CLEAR) begin
      drive_nxt    = '0;
      axis_out_nxt = 1'b0;
    end else begin
      drive_nxt    = ax3_ok ? acc_sat[DRIVE_W-1:0] : '0;
      axis_out_nxt = s3_ax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s3_fire) begin
      if (s3_op_r == OP_CLEAR) begin
        acc_r <= '0;
      end else if (ax3_ok) begin
        acc_r[ax3_idx] <= acc_sat[DRIVE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_drive_r <= drive_nxt;
      out_axis_r  <= axis_out_nxt;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_drive_r;
  assign out_tuser[0] = out_axis_r;

  // ---------------------------------------------------------------- checks
  logic signed [DRIVE_W:0] drive_ext, olim_chk;
  logic                    drive_in_range;

  assign drive_ext      = (DRIVE_W+1)'(out_drive_r);
  assign olim_chk       = $signed({2'b00, cfg.output_limit});
  assign drive_in_range = (drive_ext <= olim_chk) && (drive_ext >= -olim_chk);

  `ASSERT_IMPL(a_drive_in_range, out_v_r, drive_in_range)
  `ASSERT_NEXT(a_acc_only_on_fire, !s3_fire, $stable(acc_r))
  `ASSERT_NEXT(a_prev_only_on_fire, !s1_fire, $stable(prev_r))
  `ASSERT_NEXT(a_clear_zeroes_acc, s3_fire && s3_op_r == OP_CLEAR, acc_r == '0)

endmodule

// ===== rtl/dapid_cfg.sv =====
// ---------------------------------------------------------------------------
// dapid_cfg
// Configuration register file: write-only gains and limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dapid_cfg
  import dapid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain         <= P_GAIN_RST;
      cfg_r.i_gain         <= I_GAIN_RST;
      cfg_r.d_gain         <= D_GAIN_RST;
      cfg_r.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg_r.output_limit   <= OUTPUT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_P_GAIN:         cfg_r.p_gain         <= cfg_data;
        REG_I_GAIN:         cfg_r.i_gain         <= cfg_data;
        REG_D_GAIN:         cfg_r.d_gain         <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_r.output_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb - two-axis incremental PID controller testbench
// Drives step and clear transactions into dual_axis_incremental_pid_top
// under several register settings (reset values, all-max, all-zero gains,
// zero limits, random), with random source gaps and sink stalls. A small
// scoreboard mirrors the controller state, predicts every drive value and
// checks the result stream field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dapid_pkg::*;

  localparam int POS_W          = 16;
  localparam int TDATA_W        = ((2*POS_W+7)/8)*8;
  localparam int PIPE_LATENCY   = 3;      // input transaction to out_tvalid
  localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transaction at all

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, per-axis last error and
  // accumulator; one expected drive per accepted input transaction.
  // -------------------------------------------------------------------------
  class pid_drive_scoreboard;
    typedef struct packed {
      logic              axis;
      logic signed [15:0] drive;
    } drive_item_t;

    logic [GAIN_W-1:0]  kp, ki, kd;
    logic [LIMIT_W-1:0] int_lim, out_lim;
    logic signed [POS_W:0] last_err [2];
    logic signed [15:0]    drive_acc [2];
    drive_item_t expected_drives [$];
    int errors, n_steps, n_clears, n_checked, n_settings;

    function new();
      kp      = P_GAIN_RST;
      ki      = I_GAIN_RST;
      kd      = D_GAIN_RST;
      int_lim = INTEGRAL_LIMIT_RST;
      out_lim = OUTPUT_LIMIT_RST;
      for (int a = 0; a < 2; a++) begin
        last_err[a]  = '0;
        drive_acc[a] = '0;
      end
      errors     = 0;
      n_steps    = 0;
      n_clears   = 0;
      n_checked  = 0;
      n_settings = 1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        REG_P_GAIN:         kp = val;
        REG_I_GAIN:         ki = val;
        REG_D_GAIN:         kd = val;
        REG_INTEGRAL_LIMIT: int_lim = val[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   out_lim = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted input transaction -> expected drive
    function void predict_drive(logic op, logic ax, logic signed [POS_W-1:0] meas,
                                logic signed [POS_W-1:0] targ);
      longint err, pt, it, dt, ilim_q, sum, step_int, acc, lim;
      drive_item_t item;
      if (op == OP_CLEAR) begin
        drive_acc[0] = '0;
        drive_acc[1] = '0;
        item.axis  = 1'b0;
        item.drive = '0;
        n_clears++;
      end else begin
        err = longint'(meas) - longint'(targ);
        pt  = longint'(kp) * err;
        it  = longint'(ki) * err;
        ilim_q = longint'(int_lim) * 65536;
        if (it >= ilim_q) it = ilim_q;
        if (it <= -ilim_q) it = -ilim_q;
        dt = longint'(kd) * (err - longint'(last_err[ax]));
        last_err[ax] = err[POS_W:0];
        sum = pt + it + dt;
        // truncate toward zero
        step_int = (sum < 0) ? -((-sum) >>> FRAC_W) : (sum >>> FRAC_W);
        acc = longint'(drive_acc[ax]) + step_int;
        lim = longint'(out_lim);
        if (acc <= -lim) acc = -lim;
        if (acc >= lim) acc = lim;
        drive_acc[ax] = acc[15:0];
        item.axis  = ax;
        item.drive = acc[15:0];
        n_steps++;
      end
      expected_drives.push_back(item);
    endfunction

    function void check_drive(logic ax, logic [DRIVE_W-1:0] drive);
      drive_item_t exp_item;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result axis %0d drive %0d", $time, ax, $signed(drive));
        errors++;
        return;
      end
      exp_item = expected_drives.pop_front();
      n_checked++;
      if (exp_item.axis !== ax) begin
        $display("%0t: axis_out expected %0d actual %0d", $time, exp_item.axis, ax);
        errors++;
      end
      if (exp_item.drive !== drive) begin
        $display("%0t: drive expected %0d actual %0d", $time, exp_item.drive,
                 $signed(drive));
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT signals; every DUT input is driven to a known value from time zero
  // -------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata  = '0;   // measured_position, target_position
  logic [1:0]           in_tuser  = '0;   // operation [0], axis [1]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DRIVE_W-1:0]   out_tdata;        // drive
  logic [0:0]           out_tuser;        // axis_out

  pid_drive_scoreboard sb = new();

  // per-phase switches for back-to-back stretches
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int idle_cycles = 0;

  dual_axis_incremental_pid_top #(
    .AXIS_COUNT   (2),
    .POSITION_BITS(POS_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Watchdog: any cycle without a transaction on either stream counts.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d drives outstanding", $time,
               sb.expected_drives.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Result sink: random stall before each result. tready stays
  // high across back-to-back results (single NBA per step).
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_drive(out_tuser[0], out_tdata);
    end
  end

  // -------------------------------------------------------------------------
  // Source side tasks. All called at a rising edge; they return on the edge
  // where the transaction is accepted.
  // -------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic ax,
                           input logic signed [POS_W-1:0] meas,
                           input logic signed [POS_W-1:0] targ);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({targ, meas});
    in_tuser  <= {ax, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_drive(op, ax, meas, targ);
  endtask

  // Mostly small tracking errors so the accumulator moves without pinning
  // at the limit; the rest full-range, extremes, zero error and clears.
  task automatic send_random_item(input int clear_pct);
    int   kind, t, m;
    logic ax;
    ax   = 1'($urandom_range(0, 1));
    t    = int'($urandom_range(0, 65535)) - 32768;
    kind = $urandom_range(0, 99);
    if (kind < clear_pct) begin
      // clear ignores axis and positions; keep them random
      send_item(OP_CLEAR, ax, POS_W'($urandom), POS_W'($urandom));
    end else begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: m = t + int'($urandom_range(0, 128)) - 64;
        6, 7: m = int'($urandom_range(0, 65535)) - 32768;
        8: begin
          m = $urandom_range(0, 1) ? 32767 : -32768;
          t = $urandom_range(0, 1) ? 32767 : -32768;
        end
        default: m = t;
      endcase
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      send_item(OP_STEP, ax, POS_W'(m), POS_W'(t));
    end
  endtask

  // Drop valid, wait for every expected drive, then let the pipe empty.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int clear_pct);
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    repeat (count) send_random_item(clear_pct);
    finish_phase();
  endtask

  // Writes all five registers back to back; block is idle here.
  task automatic load_settings(input logic [GAIN_W-1:0] kp, ki, kd,
                               input logic [LIMIT_W-1:0] il, ol);
    logic [CFG_IDX_W-1:0] idx  [5];
    logic [GAIN_W-1:0]    vals [5];
    idx[0] = REG_P_GAIN;         vals[0] = kp;
    idx[1] = REG_I_GAIN;         vals[1] = ki;
    idx[2] = REG_D_GAIN;         vals[2] = kd;
    idx[3] = REG_INTEGRAL_LIMIT; vals[3] = GAIN_W'(il);
    idx[4] = REG_OUTPUT_LIMIT;   vals[4] = GAIN_W'(ol);
    cfg_wr_en <= 1'b1;
    for (int r = 0; r < 5; r++) begin
      cfg_index <= idx[r];
      cfg_data  <= vals[r];
      @(posedge clk);
      sb.set_register(idx[r], vals[r]);
    end
    cfg_wr_en <= 1'b0;
    sb.n_settings++;
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(0, 9) < 7) return GAIN_W'($urandom_range(0, 131071));
    return GAIN_W'($urandom);
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return LIMIT_W'($urandom);
    if (pick == 1) return LIMIT_W'($urandom_range(0, 64));
    return LIMIT_W'($urandom_range(0, 1000));
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at reset values: zero error, both signs, full-scale error
    // (output saturates), repeated step (derivative zero), clears with
    // either axis value, equal extremes.
    src_steady = 1'b0;
    send_item(OP_STEP,  1'b0, 16'sd0,      16'sd0);
    send_item(OP_STEP,  1'b0, 16'sd100,    16'sd0);
    send_item(OP_STEP,  1'b1, -16'sd100,   16'sd0);
    send_item(OP_STEP,  1'b0, 16'sd32767,  -16'sd32768);
    send_item(OP_STEP,  1'b1, -16'sd32768, 16'sd32767);
    send_item(OP_STEP,  1'b1, -16'sd32768, 16'sd32767);
    send_item(OP_CLEAR, 1'b1, 16'sd1234,   -16'sd77);
    send_item(OP_STEP,  1'b0, 16'sd5,      16'sd10);
    send_item(OP_STEP,  1'b0, -16'sd32768, -16'sd32768);
    send_item(OP_STEP,  1'b1, 16'sd32767,  16'sd32767);
    send_item(OP_CLEAR, 1'b0, 16'sd0,      16'sd0);
    send_item(OP_STEP,  1'b1, 16'sd1000,   16'sd0);
    finish_phase();

    // back-to-back stretch at reset values
    run_phase(120, 8);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    repeat (40) send_random_item(5);
    finish_phase();

    // All registers at maximum: large terms, derivative of full-scale swings.
    load_settings('1, '1, '1, '1, '1);
    send_item(OP_STEP, 1'b0, 16'sd32767,  -16'sd32768);
    send_item(OP_STEP, 1'b0, -16'sd32768, 16'sd32767);
    send_item(OP_STEP, 1'b1, -16'sd32768, 16'sd32767);
    send_item(OP_STEP, 1'b1, 16'sd32767,  -16'sd32768);
    finish_phase();
    run_phase(80, 5);

    // Zero gains: drive must hold.
    load_settings('0, '0, '0, rand_limit(), rand_limit());
    run_phase(50, 10);

    // Zero output limit: accumulator pinned to zero.
    load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), '0);
    run_phase(50, 10);

    // Zero integral limit: I term drops out.
    load_settings(rand_gain(), rand_gain(), rand_gain(), '0, LIMIT_W'(32767));
    run_phase(100, 8);

    // Reset values written explicitly.
    load_settings(P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, INTEGRAL_LIMIT_RST,
                  OUTPUT_LIMIT_RST);
    run_phase(110, 5);

    // Random settings
    repeat (5) begin
      load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
      run_phase(100, 6);
    end

    // everything drained by finish_phase; allow stray results to show up
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    $display("Covered %0d steps and %0d clears under %0d register settings.",
             sb.n_steps, sb.n_clears, sb.n_settings);
    $display("%0d drives checked, %0d mismatches, %0d outstanding.",
             sb.n_checked, sb.errors, sb.expected_drives.size());
    if (sb.errors == 0 && sb.expected_drives.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dapid_pkg.sv
rtl/dapid_cfg.sv
rtl/dual_axis_incremental_pid_top.sv
tb/tb.sv
